/* sv/minmax_injection_svpwm_unit_assert.svh */
// Assertion macros for the min-max injection SVPWM unit.
// Used by the checker module; needs clk and arst_n in scope.
`ifndef MINMAX_INJECTION_SVPWM_UNIT_ASSERT_SVH
`define MINMAX_INJECTION_SVPWM_UNIT_ASSERT_SVH

// check a consequence in the same cycle
`define MMSV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// check a consequence in the next cycle
`define MMSV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/mmsvpwm_pkg.sv */
// Shared widths, codes and types of the min-max injection SVPWM unit.
// No dependencies.
`default_nettype none
package mmsvpwm_pkg;
	localparam int VOLT_W    = 16;
	localparam int FRAC_W    = 16;
	localparam int DUTY_W    = FRAC_W + 1;
	localparam int CMP_W     = 16;
	localparam int DIV_NUM_W = 34;
	localparam int DIV_DEN_W = 18;
	localparam int DIV_Q_W   = 17;
	localparam int LANE_LAT  = DIV_Q_W + 2;
	localparam logic [DUTY_W-1:0] ONE_Q  = DUTY_W'(1) << FRAC_W;
	localparam logic [DUTY_W-1:0] HALF_Q = DUTY_W'(1) << (FRAC_W - 1);

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_PERIOD_ZERO = 2'd1,
		ST_BUS_LOW     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_PERIOD  = 2'd0,
		REG_FLOOR   = 2'd1,
		REG_CEILING = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CMP_W-1:0]  period;
		logic [DUTY_W-1:0] lo;
		logic [DUTY_W-1:0] hi;
	} lim_cfg_t;

	typedef struct packed {
		status_t          status;
		logic             lim;
		logic             neg;
		logic [VOLT_W-1:0] off_plain;
	} side_t;
endpackage
`default_nettype wire

/* sv/minmax_injection_svpwm_unit.sv */
// Top level: min-max common-mode injection SVPWM with APB registers.
// Depends on mmsvpwm_pkg, mmsvpwm_div and mmsvpwm_lane.
//
// channel   ports                                   handshake
// request   volt_a/b/c, bus_volt                    start while busy low
// result    cmp_*, duty_out_*, offset_volt, ...     done, one cycle
// config    psel/penable/pwrite/paddr/pwdata        APB, pready high
//
// A request is taken every cycle; its result passes the stage 1 and stage 2
// registers, the lanes and the output registers and is taken with done.
// The pipeline length is set by the 17-stage bit-per-stage dividers, one per phase
// lane plus one for scale and one for offset.
// busy stays low; reset clears the pipeline valids and restores registers.
// The receiver cannot stall: done lasts one cycle.
`default_nettype none
module minmax_injection_svpwm_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] volt_a,
	input  logic signed [15:0] volt_b,
	input  logic signed [15:0] volt_c,
	input  logic signed [15:0] bus_volt,
	output logic               done,
	output logic [15:0]        cmp_a,
	output logic [15:0]        cmp_b,
	output logic [15:0]        cmp_c,
	output logic [16:0]        duty_out_a,
	output logic [16:0]        duty_out_b,
	output logic [16:0]        duty_out_c,
	output logic signed [15:0] offset_volt,
	output logic [16:0]        scale_factor,
	output logic               was_limited,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mmsvpwm_pkg::*;

	localparam int LANES = 3;

	logic [CMP_W-1:0]  pwm_period_q;
	logic [DUTY_W-1:0] duty_floor_q;
	logic [DUTY_W-1:0] duty_ceiling_q;
	lim_cfg_t          cfg;
	reg_idx_t          ridx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q   <= CMP_W'(3399);
			duty_floor_q   <= '0;
			duty_ceiling_q <= ONE_Q;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_PERIOD:  pwm_period_q   <= pwdata[CMP_W-1:0];
				REG_FLOOR:   duty_floor_q   <= pwdata[DUTY_W-1:0];
				REG_CEILING: duty_ceiling_q <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_PERIOD:  prdata = 32'(pwm_period_q);
			REG_FLOOR:   prdata = 32'(duty_floor_q);
			REG_CEILING: prdata = 32'(duty_ceiling_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.period = pwm_period_q;
	assign cfg.lo     = (duty_floor_q > ONE_Q) ? ONE_Q : duty_floor_q;
	assign cfg.hi     = (duty_ceiling_q > ONE_Q) ? ONE_Q : duty_ceiling_q;

	// stage 1: extremes, span, status
	logic signed [VOLT_W-1:0] vmax, vmin;
	logic signed [VOLT_W:0]   span_w;
	logic [VOLT_W-1:0]        span;
	status_t                  st;

	always_comb begin
		vmax = volt_a;
		vmin = volt_a;
		if (volt_b > vmax) vmax = volt_b;
		if (volt_c > vmax) vmax = volt_c;
		if (volt_b < vmin) vmin = volt_b;
		if (volt_c < vmin) vmin = volt_c;
		span_w = (VOLT_W+1)'(vmax) - (VOLT_W+1)'(vmin);
		span   = span_w[VOLT_W-1:0];
		if (pwm_period_q == '0) st = ST_PERIOD_ZERO;
		else if (bus_volt[VOLT_W-1] || bus_volt == '0) st = ST_BUS_LOW;
		else st = ST_OK;
	end

	logic                     valid_s1;
	logic signed [VOLT_W-1:0] v_s1 [LANES];
	logic signed [VOLT_W-1:0] vmax_s1, vmin_s1;
	logic [VOLT_W-1:0]        span_s1, bus_s1;
	logic                     lim_s1;
	status_t                  st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start;
	end

	always_ff @(posedge clk) begin
		v_s1[0] <= volt_a;
		v_s1[1] <= volt_b;
		v_s1[2] <= volt_c;
		vmax_s1 <= vmax;
		vmin_s1 <= vmin;
		span_s1 <= span;
		bus_s1  <= bus_volt;
		lim_s1  <= {1'b0, span} > {1'b0, bus_volt};
		st_s1   <= st;
	end

	// stage 2: divider operands and offset product
	logic [VOLT_W-1:0]        den;
	logic signed [VOLT_W:0]   msum;
	logic [VOLT_W:0]          mag;
	logic [2*VOLT_W:0]        oprod;
	logic [VOLT_W+1:0]        mag_inc;
	logic [DIV_NUM_W-1:0]     lane_num [LANES];

	assign den     = lim_s1 ? span_s1 : bus_s1;
	assign msum    = (VOLT_W+1)'(vmax_s1) + (VOLT_W+1)'(vmin_s1);
	assign mag     = msum[VOLT_W] ? (VOLT_W+1)'(-msum) : (VOLT_W+1)'(msum);
	assign oprod   = mag * bus_s1;
	assign mag_inc = (VOLT_W+2)'(mag) + (VOLT_W+2)'(1);

	for (genvar k = 0; k < LANES; k++) begin : g_op
		logic signed [VOLT_W+2:0] xs;
		assign xs = (VOLT_W+3)'(signed'({3'b000, den})) + ((VOLT_W+3)'(v_s1[k]) <<< 1)
			- (VOLT_W+3)'(vmax_s1) - (VOLT_W+3)'(vmin_s1);
		assign lane_num[k] = (DIV_NUM_W'(xs[VOLT_W+1:0]) << FRAC_W) + DIV_NUM_W'(den);
	end

	logic                 valid_s2;
	logic [DIV_NUM_W-1:0] num_s2 [LANES];
	logic [DIV_DEN_W-1:0] den_s2;
	logic [DIV_NUM_W-1:0] sc_num_s2, of_num_s2;
	logic [DIV_DEN_W-1:0] sc_den_s2, of_den_s2;
	side_t                side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) num_s2[k] <= lane_num[k];
		den_s2    <= DIV_DEN_W'({den, 1'b0});
		sc_num_s2 <= DIV_NUM_W'(bus_s1) << FRAC_W;
		sc_den_s2 <= DIV_DEN_W'(span_s1);
		of_num_s2 <= DIV_NUM_W'({oprod, 1'b0}) + DIV_NUM_W'({span_s1, 1'b0});
		of_den_s2 <= DIV_DEN_W'({span_s1, 2'b00});
		side_s2.status    <= st_s1;
		side_s2.lim       <= lim_s1;
		side_s2.neg       <= (msum != '0) && !msum[VOLT_W];
		side_s2.off_plain <= mag_inc[VOLT_W:1];
	end

	// lanes
	logic [DUTY_W-1:0] duty_l [LANES];
	logic [CMP_W-1:0]  cmp_l  [LANES];

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		mmsvpwm_lane u_lane (
			.clk(clk), .num(num_s2[k]), .den(den_s2), .cfg(cfg),
			.duty(duty_l[k]), .cmp(cmp_l[k])
		);
	end

	logic [DIV_Q_W-1:0] sc_quo, of_quo;

	mmsvpwm_div u_sc_div (.clk(clk), .num(sc_num_s2), .den(sc_den_s2), .quo(sc_quo));
	mmsvpwm_div u_of_div (.clk(clk), .num(of_num_s2), .den(of_den_s2), .quo(of_quo));

	logic [DIV_Q_W-1:0] sc_dly_q [2];
	logic [DIV_Q_W-1:0] of_dly_q [2];
	side_t              side_pipe_q [LANE_LAT];
	logic [LANE_LAT-1:0] vld_pipe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_pipe_q <= '0;
		else vld_pipe_q <= {vld_pipe_q[LANE_LAT-2:0], valid_s2};
	end

	always_ff @(posedge clk) begin
		sc_dly_q[0] <= sc_quo;
		sc_dly_q[1] <= sc_dly_q[0];
		of_dly_q[0] <= of_quo;
		of_dly_q[1] <= of_dly_q[0];
		side_pipe_q[0] <= side_s2;
		for (int k = 1; k < LANE_LAT; k++) side_pipe_q[k] <= side_pipe_q[k-1];
	end

	// merge
	side_t                    sd;
	logic [DIV_Q_W-1:0]       omag;
	logic signed [VOLT_W-1:0] ofs;
	logic [CMP_W:0]           mid_w;

	assign sd    = side_pipe_q[LANE_LAT-1];
	assign omag  = sd.lim ? of_dly_q[1] : DIV_Q_W'(sd.off_plain);
	assign mid_w = ((CMP_W+1)'(pwm_period_q) + (CMP_W+1)'(1)) >> 1;

	always_comb begin
		if (!sd.neg && omag > DIV_Q_W'(16'h7FFF)) ofs = 16'sh7FFF;
		else if (sd.neg) ofs = VOLT_W'(-omag);
		else ofs = VOLT_W'(omag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_pipe_q[LANE_LAT-1];
	end

	always_ff @(posedge clk) begin
		status <= sd.status;
		if (sd.status == ST_OK) begin
			cmp_a        <= cmp_l[0];
			cmp_b        <= cmp_l[1];
			cmp_c        <= cmp_l[2];
			duty_out_a   <= duty_l[0];
			duty_out_b   <= duty_l[1];
			duty_out_c   <= duty_l[2];
			offset_volt  <= ofs;
			scale_factor <= sd.lim ? sc_dly_q[1] : ONE_Q;
			was_limited  <= sd.lim;
		end else begin
			cmp_a        <= (sd.status == ST_BUS_LOW) ? mid_w[CMP_W-1:0] : '0;
			cmp_b        <= (sd.status == ST_BUS_LOW) ? mid_w[CMP_W-1:0] : '0;
			cmp_c        <= (sd.status == ST_BUS_LOW) ? mid_w[CMP_W-1:0] : '0;
			duty_out_a   <= HALF_Q;
			duty_out_b   <= HALF_Q;
			duty_out_c   <= HALF_Q;
			offset_volt  <= '0;
			scale_factor <= ONE_Q;
			was_limited  <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* sv/mmsvpwm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mmsvpwm_pkg; quotient must fit DIV_Q_W bits.
`default_nettype none
module mmsvpwm_div (
	input  logic                            clk,
	input  logic [mmsvpwm_pkg::DIV_NUM_W-1:0] num,
	input  logic [mmsvpwm_pkg::DIV_DEN_W-1:0] den,
	output logic [mmsvpwm_pkg::DIV_Q_W-1:0]   quo
);
	import mmsvpwm_pkg::*;

	localparam int REM_W = DIV_DEN_W;
	localparam int LOW_W = DIV_Q_W;

	logic [REM_W-1:0]     rem_s [DIV_Q_W];
	logic [DIV_Q_W-1:0]   quo_s [DIV_Q_W];
	logic [LOW_W-1:0]     low_s [DIV_Q_W];
	logic [DIV_DEN_W-1:0] den_s [DIV_Q_W];

	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_st
		logic [REM_W-1:0]     r_in;
		logic [LOW_W-1:0]     l_in;
		logic [DIV_Q_W-1:0]   q_in;
		logic [DIV_DEN_W-1:0] d_in;
		logic [REM_W:0]       trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign r_in = REM_W'(num[DIV_NUM_W-1:LOW_W]);
			assign l_in = num[LOW_W-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
		end

		assign trial = {r_in, l_in[LOW_W-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? REM_W'(trial - {1'b0, d_in}) : REM_W'(trial);
			quo_s[k] <= {q_in[DIV_Q_W-2:0], ge};
			low_s[k] <= {l_in[LOW_W-2:0], 1'b0};
			den_s[k] <= d_in;
		end
	end

	assign quo = quo_s[DIV_Q_W-1];
endmodule
`default_nettype wire

/* sv/mmsvpwm_lane.sv */
// One phase lane: duty divide, clamp to limits, scale to compare counts.
// Depends on mmsvpwm_pkg and mmsvpwm_div.
`default_nettype none
module mmsvpwm_lane (
	input  logic                              clk,
	input  logic [mmsvpwm_pkg::DIV_NUM_W-1:0] num,
	input  logic [mmsvpwm_pkg::DIV_DEN_W-1:0] den,
	input  mmsvpwm_pkg::lim_cfg_t             cfg,
	output logic [mmsvpwm_pkg::DUTY_W-1:0]    duty,
	output logic [mmsvpwm_pkg::CMP_W-1:0]     cmp
);
	import mmsvpwm_pkg::*;

	logic [DIV_Q_W-1:0]        quo;
	logic [DUTY_W-1:0]         clamped;
	logic [DUTY_W-1:0]         duty_s1;
	logic [DUTY_W+CMP_W-1:0]   prod;
	logic [DUTY_W-1:0]         duty_s2;
	logic [CMP_W-1:0]          cmp_s2;

	mmsvpwm_div u_div (.clk(clk), .num(num), .den(den), .quo(quo));

	always_comb begin
		clamped = DUTY_W'(quo);
		if (clamped < cfg.lo) clamped = cfg.lo;
		if (clamped > cfg.hi) clamped = cfg.hi;
	end

	assign prod = duty_s1 * cfg.period;

	always_ff @(posedge clk) begin
		duty_s1 <= clamped;
		duty_s2 <= duty_s1;
		cmp_s2  <= prod[FRAC_W+CMP_W-1:FRAC_W];
	end

	assign duty = duty_s2;
	assign cmp  = cmp_s2;
endmodule
`default_nettype wire

/* sv/mmsvpwm_checker.sv */
// Port-level checks of the min-max injection SVPWM unit, bound to the top.
// Depends on mmsvpwm_pkg and minmax_injection_svpwm_unit_assert.svh.
`default_nettype none
`include "minmax_injection_svpwm_unit_assert.svh"
module mmsvpwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        busy,
	input logic [15:0] cmp_a,
	input logic [15:0] cmp_b,
	input logic [15:0] cmp_c,
	input logic [16:0] duty_out_a,
	input logic [16:0] scale_factor,
	input logic        was_limited,
	input logic [1:0]  status
);
	import mmsvpwm_pkg::*;

	`MMSV_ASSERT_NOW(a_zero_period_cmp, done && status == ST_PERIOD_ZERO, cmp_a == '0 && cmp_b == '0 && cmp_c == '0)
	`MMSV_ASSERT_NOW(a_err_fixed, done && status != ST_OK, duty_out_a == HALF_Q && scale_factor == ONE_Q && !was_limited)
	`MMSV_ASSERT_NOW(a_unlim_scale, done && status == ST_OK && !was_limited, scale_factor == ONE_Q)
	`MMSV_ASSERT_NOW(a_bus_low_mid, done && status == ST_BUS_LOW, cmp_a == cmp_b && cmp_b == cmp_c)
	`MMSV_ASSERT_NEXT(a_never_busy, 1'b1, !busy)
endmodule

bind minmax_injection_svpwm_unit mmsvpwm_checker u_chk (.*);
`default_nettype wire

/* tb/minmax_injection_svpwm_unit_checker.sv */
`timescale 1ns / 100ps
// Checker for the min-max injection SVPWM unit: tracks register writes, predicts each
// result from the accepted request and compares it with the done strobe. Needs mmsvpwm_pkg.
`default_nettype none
module minmax_injection_svpwm_unit_checker
	import mmsvpwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] volt_a,
	input  logic signed [15:0] volt_b,
	input  logic signed [15:0] volt_c,
	input  logic signed [15:0] bus_volt,
	input  logic               done,
	input  logic [15:0]        cmp_a,
	input  logic [15:0]        cmp_b,
	input  logic [15:0]        cmp_c,
	input  logic [16:0]        duty_out_a,
	input  logic [16:0]        duty_out_b,
	input  logic [16:0]        duty_out_c,
	input  logic signed [15:0] offset_volt,
	input  logic [16:0]        scale_factor,
	input  logic               was_limited,
	input  logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 pending,
	output int                 failures
);
	typedef struct packed {
		logic [15:0] cmp_a, cmp_b, cmp_c;
		logic [16:0] duty_a, duty_b, duty_c;
		logic [15:0] offset;
		logic [16:0] scale;
		logic        limited;
		logic [1:0]  st;
	} svpwm_result_t;

	svpwm_result_t compare_queue[$];
	logic [15:0] period_reg;
	logic [16:0] floor_reg, ceiling_reg;

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		failures++;
	endtask

	function automatic longint clamp_duty(input longint d);
		longint lo, hi;
		lo = floor_reg > ONE_Q ? longint'(ONE_Q) : longint'(floor_reg);
		hi = ceiling_reg > ONE_Q ? longint'(ONE_Q) : longint'(ceiling_reg);
		if (d < lo) d = lo;
		if (d > hi) d = hi;
		return d;
	endfunction

	function automatic svpwm_result_t predict_pwm(input logic signed [15:0] va, vb, vc, vbus);
		svpwm_result_t r;
		longint v[3], duty[3], vmax, vmin, span, den, bus, t, mag, mul, dv, q, offs, x, per;
		logic lim;
		per = longint'(period_reg);
		bus = longint'(vbus);
		v[0] = longint'(va); v[1] = longint'(vb); v[2] = longint'(vc);
		r = '0;
		r.duty_a = HALF_Q; r.duty_b = HALF_Q; r.duty_c = HALF_Q;
		r.scale = ONE_Q;
		if (per == 0) begin
			r.st = ST_PERIOD_ZERO;
			return r;
		end
		if (bus <= 0) begin
			q = (per + 1) >> 1;
			if (q > per) q = per;
			r.cmp_a = 16'(q); r.cmp_b = 16'(q); r.cmp_c = 16'(q);
			r.st = ST_BUS_LOW;
			return r;
		end
		vmax = v[0]; vmin = v[0];
		for (int k = 1; k < 3; k++) begin
			if (v[k] > vmax) vmax = v[k];
			if (v[k] < vmin) vmin = v[k];
		end
		span = vmax - vmin;
		lim = span > bus;
		den = lim ? span : bus;
		r.scale = lim ? 17'((bus << FRAC_W) / span) : ONE_Q;
		for (int k = 0; k < 3; k++) begin
			x = den + 2 * v[k] - vmax - vmin;
			duty[k] = clamp_duty(((x << FRAC_W) + den) / (2 * den));
		end
		r.duty_a = 17'(duty[0]); r.duty_b = 17'(duty[1]); r.duty_c = 17'(duty[2]);
		r.cmp_a = 16'((duty[0] * per) >> FRAC_W);
		r.cmp_b = 16'((duty[1] * per) >> FRAC_W);
		r.cmp_c = 16'((duty[2] * per) >> FRAC_W);
		t = -(vmax + vmin);
		mag = t < 0 ? -t : t;
		mul = lim ? bus : 1;
		dv = lim ? 2 * span : 2;
		q = (2 * mag * mul + dv) / (2 * dv);
		offs = t < 0 ? -q : q;
		if (offs > 32767) offs = 32767;
		if (offs < -32768) offs = -32768;
		r.offset = 16'(offs);
		r.limited = lim;
		r.st = ST_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		svpwm_result_t w;
		if (!arst_n) begin
			period_reg  <= 16'd3399;
			floor_reg   <= '0;
			ceiling_reg <= ONE_Q;
			compare_queue.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_PERIOD:  period_reg  <= pwdata[15:0];
					REG_FLOOR:   floor_reg   <= pwdata[16:0];
					REG_CEILING: ceiling_reg <= pwdata[16:0];
					default: ;
				endcase
			end
			if (start && !busy)
				compare_queue.push_back(predict_pwm(volt_a, volt_b, volt_c, bus_volt));
			if (done) begin
				if (compare_queue.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					failures++;
				end else begin
					w = compare_queue.pop_front();
					if (cmp_a !== w.cmp_a)
						report_mismatch("cmp_a", longint'(cmp_a), longint'(w.cmp_a));
					if (cmp_b !== w.cmp_b)
						report_mismatch("cmp_b", longint'(cmp_b), longint'(w.cmp_b));
					if (cmp_c !== w.cmp_c)
						report_mismatch("cmp_c", longint'(cmp_c), longint'(w.cmp_c));
					if (duty_out_a !== w.duty_a)
						report_mismatch("duty_a", longint'(duty_out_a), longint'(w.duty_a));
					if (duty_out_b !== w.duty_b)
						report_mismatch("duty_b", longint'(duty_out_b), longint'(w.duty_b));
					if (duty_out_c !== w.duty_c)
						report_mismatch("duty_c", longint'(duty_out_c), longint'(w.duty_c));
					if (offset_volt !== w.offset)
						report_mismatch("offset", longint'(offset_volt),
							longint'($signed(w.offset)));
					if (scale_factor !== w.scale)
						report_mismatch("scale", longint'(scale_factor), longint'(w.scale));
					if (was_limited !== w.limited)
						report_mismatch("limited", longint'(was_limited), longint'(w.limited));
					if (status !== w.st)
						report_mismatch("status", longint'(status), longint'(w.st));
				end
			end
			pending <= compare_queue.size();
		end
	end
endmodule
`default_nettype wire

/* tb/minmax_injection_svpwm_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the min-max injection SVPWM unit: clock, reset, request and register
// stimulus, watchdog and verdict. Needs mmsvpwm_pkg and the checker module.
`default_nettype none
module minmax_injection_svpwm_unit_tb;
	import mmsvpwm_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 30;

	logic clk, arst_n, start, busy, done, was_limited, psel, penable, pwrite, pready;
	logic signed [15:0] volt_a, volt_b, volt_c, bus_volt, offset_volt;
	logic [15:0] cmp_a, cmp_b, cmp_c;
	logic [16:0] duty_out_a, duty_out_b, duty_out_c, scale_factor;
	logic [1:0]  status;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic busy_seen;
	int pending, failures, stall_cycles;

	minmax_injection_svpwm_unit dut (.*);
	minmax_injection_svpwm_unit_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) busy_seen <= busy;

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_request(input logic [15:0] a, b, c, bus);
		start    <= 1'b1;
		volt_a   <= a;
		volt_b   <= b;
		volt_c   <= c;
		bus_volt <= bus;
		do @(posedge clk); while (busy_seen);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		idle_cycles(1);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_limits(input logic [15:0] per, input logic [16:0] lo, hi);
		write_reg(REG_PERIOD, 32'(per));
		write_reg(REG_FLOOR, 32'(lo));
		write_reg(REG_CEILING, 32'(hi));
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_volt();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(2000)) - 1000);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(20000)) - 10000);
		endcase
	endfunction

	function automatic logic [15:0] rand_bus();
		case ($urandom_range(9))
			0: return 16'h8000 | 16'($urandom);
			1: return 16'd0;
			2: return 16'($urandom_range(1, 50));
			3: return 16'h7fff;
			default: return 16'($urandom_range(1, 32767));
		endcase
	endfunction

	initial begin
		logic [15:0] per_cfg[6];
		logic [16:0] lo_cfg[6], hi_cfg[6];
		arst_n = 1'b0; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0; volt_a = '0; volt_b = '0; volt_c = '0; bus_volt = '0;
		stall_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(16'h8000, 16'h8000, 16'h8000, 16'd100);
		send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'd100);
		send_request(16'h7fff, 16'h8000, 16'd0, 16'h7fff);
		send_request(16'h7fff, 16'h8000, 16'd0, 16'd1);
		send_request(16'd500, 16'hfe0c, 16'd0, 16'd0);
		send_request(16'd500, 16'hfe0c, 16'd0, 16'h8000);
		send_request(16'd100, 16'd100, 16'd100, 16'd256);
		send_request(16'd300, 16'hff00, 16'd20, 16'd256);
		send_request(16'd300, 16'hff00, 16'd20, 16'd400);
		send_request(16'd3, 16'd0, 16'hfffd, 16'd6);
		send_request(16'd1, 16'd0, 16'hffff, 16'd1);
		send_request(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_request(16'h8001, 16'h8000, 16'h8000, 16'd1);
		drain();
		set_limits(16'd0, 17'd0, 17'h10000);
		send_request(16'd300, 16'hff00, 16'd20, 16'd256);
		send_request(16'd300, 16'hff00, 16'd20, 16'h8000);
		drain();
		set_limits(16'hffff, 17'd20000, 17'd45000);
		send_request(16'h7fff, 16'h8000, 16'd0, 16'd1);
		send_request(16'd500, 16'hfe0c, 16'd0, 16'hffff);
		drain();
		set_limits(16'd1, 17'h1ffff, 17'h1ffff);
		send_request(16'd300, 16'hff00, 16'd20, 16'd256);
		send_request(16'd300, 16'hff00, 16'd20, 16'h8000);

		per_cfg = '{16'd3399, 16'hffff, 16'd1000, 16'd1, 16'd0, 16'd0};
		lo_cfg  = '{17'd0, 17'd0, 17'd50000, 17'h1ffff, 17'd3000, 17'd0};
		hi_cfg  = '{17'h10000, 17'h10000, 17'd20000, 17'h1ffff, 17'd60000, 17'h10000};
		per_cfg[5] = 16'($urandom_range(1, 65535));
		lo_cfg[5]  = 17'($urandom_range(30000));
		hi_cfg[5]  = 17'($urandom_range(35000, 131071));
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			set_limits(per_cfg[ph], lo_cfg[ph], hi_cfg[ph]);
			for (int i = 0; i < 240; i++) begin
				if (ph != 1 && $urandom_range(99) < 9) idle_cycles($urandom_range(1, 4));
				send_request(rand_volt(), rand_volt(), rand_volt(), rand_bus());
			end
		end

		drain();
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
